### hw/rtl/crfp_pkg.sv
// ----------------------------------------------------------------------------
// crfp_pkg
// types, codes and request templates shared by the call request frame parser
// ----------------------------------------------------------------------------
package crfp_pkg;

    typedef enum logic [1:0] {
        KIND_UP   = 2'd0,
        KIND_DOWN = 2'd1,
        KIND_INFO = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_RD_W1,
        OP_LD_W1,
        OP_RD_W2,
        OP_LD_W2,
        OP_RD_CMP,
        OP_LD_CMP,
        OP_RD_HOST,
        OP_LD_HOST,
        OP_RD_F35,
        OP_LD_F35,
        OP_RD_F36,
        OP_LD_F36,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic rx_ready;
        logic tx_valid;
    } t_cmd;

    typedef struct packed {
        logic frame_done;
        logic cmp_more;
        logic any_match;
        logic tx_done;
    } t_status;

    localparam int TPL_UP_LEN   = 44;
    localparam int TPL_DOWN_LEN = 46;
    localparam int TPL_INFO_LEN = 46;

    localparam logic [8*TPL_UP_LEN-1:0] TPL_UP =
        "Type=ELEVATOR&Dong=0101&Ho=1001&Direction=up";
    localparam logic [8*TPL_DOWN_LEN-1:0] TPL_DOWN =
        "Type=ELEVATOR&Dong=0101&Ho=1001&Direction=down";
    localparam logic [8*TPL_INFO_LEN-1:0] TPL_INFO =
        "Type=ELEVATOR&Dong=0101&Ho=1001&Direction=info";

    // template character, zero past the template end
    function automatic logic [7:0] tpl_byte(input t_kind kind, input logic [7:0] pos);
        logic [7:0] b;
        b = 8'h00;
        unique case (kind)
            KIND_UP: begin
                if (int'(pos) < TPL_UP_LEN) b = TPL_UP[8*(TPL_UP_LEN-1-int'(pos)) +: 8];
            end
            KIND_DOWN: begin
                if (int'(pos) < TPL_DOWN_LEN) b = TPL_DOWN[8*(TPL_DOWN_LEN-1-int'(pos)) +: 8];
            end
            KIND_INFO: begin
                if (int'(pos) < TPL_INFO_LEN) b = TPL_INFO[8*(TPL_INFO_LEN-1-int'(pos)) +: 8];
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

### hw/rtl/crfp_if.sv
// ----------------------------------------------------------------------------
// crfp channel interfaces
// valid/ready channels for received characters and reply frame bytes
// ----------------------------------------------------------------------------
interface crfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       transmit_busy;

    modport source (output valid, output rx_byte, output transmit_busy, input ready);
    modport sink   (input valid, input rx_byte, input transmit_busy, output ready);
endinterface

interface crfp_reply_if;
    logic       valid;
    logic       ready;
    logic [7:0] reply_byte;
    logic       reply_last;
    logic [1:0] command_kind;

    modport source (output valid, output reply_byte, output reply_last,
                    output command_kind, input ready);
    modport sink   (input valid, input reply_byte, input reply_last,
                    input command_kind, output ready);
endinterface

### hw/rtl/call_request_frame_parser.sv
// ----------------------------------------------------------------------------
// call_request_frame_parser
// call request text frame parser with binary reply frame generation
// ----------------------------------------------------------------------------
// a received item is taken while the parser is idle
// frame end: two width checks, a compare step per payload position, host and floor reads on a match,
//   then one reply item per cycle (6 or 8) while the output is taken
// the store walk uses one registered read port, one entry per compare step
// reset clears count, payload length and sequencer; the store is not cleared
module call_request_frame_parser #(
    parameter int BUFFER_DEPTH = 128
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    crfp_rx_if.sink      i_rx,
    crfp_reply_if.source o_reply
);

    crfp_pkg::t_cmd    cmd;
    crfp_pkg::t_status status;

    crfp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    crfp_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .i_rx     (i_rx),
        .o_reply  (o_reply)
    );

endmodule

### hw/rtl/crfp_ctrl.sv
// ----------------------------------------------------------------------------
// crfp_ctrl
// sequencer: receive, end-of-frame store walk, reply emission
// ----------------------------------------------------------------------------
module crfp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  crfp_pkg::t_status i_status,
    output crfp_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_W1_RD,
        S_W1_LD,
        S_W2_RD,
        S_W2_LD,
        S_CMP_CHK,
        S_CMP_RD,
        S_CMP_LD,
        S_HOST_RD,
        S_HOST_LD,
        S_F35_RD,
        S_F35_LD,
        S_F36_RD,
        S_F36_LD,
        S_EMIT
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (i_status.frame_done) n_state = S_W1_RD;
            S_W1_RD:   n_state = S_W1_LD;
            S_W1_LD:   n_state = S_W2_RD;
            S_W2_RD:   n_state = S_W2_LD;
            S_W2_LD:   n_state = S_CMP_CHK;
            S_CMP_CHK: begin
                priority if (i_status.cmp_more) n_state = S_CMP_RD;
                else if (i_status.any_match)    n_state = S_HOST_RD;
                else                            n_state = S_IDLE;
            end
            S_CMP_RD:  n_state = S_CMP_LD;
            S_CMP_LD:  n_state = S_CMP_CHK;
            S_HOST_RD: n_state = S_HOST_LD;
            S_HOST_LD: n_state = S_F35_RD;
            S_F35_RD:  n_state = S_F35_LD;
            S_F35_LD:  n_state = S_F36_RD;
            S_F36_RD:  n_state = S_F36_LD;
            S_F36_LD:  n_state = S_EMIT;
            S_EMIT:    if (i_status.tx_done) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd.rx_ready = (r_state == S_IDLE);
        o_cmd.tx_valid = (r_state == S_EMIT);
        unique case (r_state)
            S_W1_RD:   o_cmd.op = crfp_pkg::OP_RD_W1;
            S_W1_LD:   o_cmd.op = crfp_pkg::OP_LD_W1;
            S_W2_RD:   o_cmd.op = crfp_pkg::OP_RD_W2;
            S_W2_LD:   o_cmd.op = crfp_pkg::OP_LD_W2;
            S_CMP_RD:  o_cmd.op = crfp_pkg::OP_RD_CMP;
            S_CMP_LD:  o_cmd.op = crfp_pkg::OP_LD_CMP;
            S_HOST_RD: o_cmd.op = crfp_pkg::OP_RD_HOST;
            S_HOST_LD: o_cmd.op = crfp_pkg::OP_LD_HOST;
            S_F35_RD:  o_cmd.op = crfp_pkg::OP_RD_F35;
            S_F35_LD:  o_cmd.op = crfp_pkg::OP_LD_F35;
            S_F36_RD:  o_cmd.op = crfp_pkg::OP_RD_F36;
            S_F36_LD:  o_cmd.op = crfp_pkg::OP_LD_F36;
            S_EMIT:    o_cmd.op = crfp_pkg::OP_EMIT;
            default:   o_cmd.op = crfp_pkg::OP_NONE;
        endcase
    end

endmodule

### hw/rtl/crfp_dp.sv
// ----------------------------------------------------------------------------
// crfp_dp
// frame store, count and header check, template compare, reply frame build
// ----------------------------------------------------------------------------
module crfp_dp #(
    parameter int BUFFER_DEPTH = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  crfp_pkg::t_cmd    i_cmd,
    output crfp_pkg::t_status o_status,
    crfp_rx_if.sink           i_rx,
    crfp_reply_if.source      o_reply
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int XW = 10;

    typedef enum logic [1:0] {
        SEL_MEM,
        SEL_ZCHR,
        SEL_NUL
    } t_sel;

    function automatic logic [7:0] digit_of(input logic [7:0] v);
        return (v >= 8'h30 && v <= 8'h39) ? v - 8'h30 : 8'hff;
    endfunction

    logic [7:0]    r_mem [BUFFER_DEPTH];
    logic [AW-1:0] r_count;
    logic [7:0]    r_len;
    logic [7:0]    r_hdr [7];
    logic [7:0]    r_rdata;
    t_sel          r_sel;
    logic [7:0]    r_ie, r_i;
    logic          r_w1, r_w2;
    logic [2:0]    r_match;
    logic [7:0]    r_host, r_d35, r_floor;
    logic [2:0]    r_idx;

    // receive side
    logic          accept, in_range, wr, last_slot, hdr_chk, frame_done, hdr_ok;
    logic [AW-1:0] cnt_inc;
    logic [XW-1:0] total, hdr_val;
    logic [7:0]    c, d5, d6, d7, hdr_len;

    assign accept    = i_rx.valid && i_rx.ready;
    assign c         = i_rx.rx_byte;
    assign in_range  = (c >= 8'h10) && (c <= 8'h7f);
    assign wr        = accept && !i_rx.transmit_busy && in_range;
    assign last_slot = (r_count == AW'(BUFFER_DEPTH - 1));
    assign cnt_inc   = r_count + AW'(1);
    assign hdr_chk   = wr && !last_slot && (XW'(cnt_inc) == XW'(8));
    assign total     = XW'(r_len) + XW'(8);
    assign frame_done = wr && !last_slot && (XW'(cnt_inc) > XW'(8)) && (XW'(cnt_inc) >= total);

    // header: four '0', one unchecked, three decimal digits; last one is the incoming byte
    assign d5 = digit_of(r_hdr[5]);
    assign d6 = digit_of(r_hdr[6]);
    assign d7 = digit_of(c);
    assign hdr_ok = (r_hdr[0] == 8'h30) && (r_hdr[1] == 8'h30) && (r_hdr[2] == 8'h30)
                 && (r_hdr[3] == 8'h30) && (d5 <= 8'd9) && (d6 <= 8'd9) && (d7 <= 8'd9);
    assign hdr_val = XW'(d5[3:0]) * XW'(100) + XW'(d6[3:0]) * XW'(10) + XW'(d7[3:0]);
    assign hdr_len = (hdr_ok && hdr_val <= XW'(254)) ? hdr_val[7:0] : 8'h00;

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_count] <= c;
    end

    always_ff @(posedge i_clk) begin
        if (wr && XW'(r_count) < XW'(7)) r_hdr[r_count[2:0]] <= c;
        if (wr && last_slot) r_hdr[0] <= c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_len   <= '0;
        end else begin
            if (accept && !i_rx.transmit_busy) begin
                priority if (!in_range)                  r_count <= '0;
                else if (last_slot || frame_done)        r_count <= '0;
                else if (hdr_chk && hdr_len == 8'h00)    r_count <= '0;
                else                                     r_count <= cnt_inc;
            end
            if (hdr_chk) r_len <= hdr_len;
        end
    end

    // text position seen through the two field widenings
    logic [XW-1:0] pos, q, r;
    logic [7:0]    ie;
    t_sel          map_sel;

    assign ie = (r_i == 8'd19) ? 8'd23 : ((r_i == 8'd27) ? 8'd31 : r_i);

    always_comb begin
        unique case (i_cmd.op)
            crfp_pkg::OP_RD_W1:   pos = XW'(31);
            crfp_pkg::OP_RD_W2:   pos = XW'(39);
            crfp_pkg::OP_RD_HOST: pos = XW'(30);
            crfp_pkg::OP_RD_F35:  pos = XW'(35);
            crfp_pkg::OP_RD_F36:  pos = XW'(36);
            default:              pos = XW'(ie) + XW'(8);
        endcase
        q = (r_w2 && pos > XW'(35)) ? pos - XW'(1) : pos;
        r = (r_w1 && q > XW'(27)) ? q - XW'(1) : q;
        priority if (r_w2 && pos == XW'(35)) map_sel = SEL_ZCHR;
        else if (r_w1 && q == XW'(27))       map_sel = SEL_ZCHR;
        else if (r >= total)                 map_sel = SEL_NUL;
        else                                 map_sel = SEL_MEM;
    end

    logic       is_rd;
    logic [7:0] v, dv;
    crfp_pkg::t_kind kind;

    assign is_rd = (i_cmd.op == crfp_pkg::OP_RD_W1) || (i_cmd.op == crfp_pkg::OP_RD_W2)
                || (i_cmd.op == crfp_pkg::OP_RD_CMP) || (i_cmd.op == crfp_pkg::OP_RD_HOST)
                || (i_cmd.op == crfp_pkg::OP_RD_F35) || (i_cmd.op == crfp_pkg::OP_RD_F36);

    always_comb begin
        unique case (r_sel)
            SEL_MEM:  v = r_rdata;
            SEL_ZCHR: v = 8'h30;
            default:  v = 8'h00;
        endcase
    end
    assign dv = digit_of(v);

    assign kind = r_match[0] ? crfp_pkg::KIND_UP
                : (r_match[1] ? crfp_pkg::KIND_DOWN : crfp_pkg::KIND_INFO);

    always_ff @(posedge i_clk) begin
        if (is_rd) begin
            r_rdata <= r_mem[r[AW-1:0]];
            r_sel   <= map_sel;
            r_ie    <= ie;
        end
    end

    logic tx_take, tx_last;
    assign tx_take = i_cmd.tx_valid && o_reply.ready;

    always_ff @(posedge i_clk) begin
        if (frame_done) begin
            r_w1    <= 1'b0;
            r_w2    <= 1'b0;
            r_match <= 3'b111;
            r_i     <= 8'd0;
            r_idx   <= 3'd0;
        end
        unique case (i_cmd.op)
            crfp_pkg::OP_LD_W1: r_w1 <= (v != 8'h26);
            crfp_pkg::OP_LD_W2: r_w2 <= (v != 8'h26);
            crfp_pkg::OP_LD_CMP: begin
                if (v != crfp_pkg::tpl_byte(crfp_pkg::KIND_UP, r_ie))   r_match[0] <= 1'b0;
                if (v != crfp_pkg::tpl_byte(crfp_pkg::KIND_DOWN, r_ie)) r_match[1] <= 1'b0;
                if (v != crfp_pkg::tpl_byte(crfp_pkg::KIND_INFO, r_ie)) r_match[2] <= 1'b0;
                r_i <= r_ie + 8'd1;
            end
            crfp_pkg::OP_LD_HOST: r_host <= dv - 8'd1;
            crfp_pkg::OP_LD_F35:  r_d35 <= dv;
            crfp_pkg::OP_LD_F36: begin
                r_floor <= (8'({r_d35, 3'b000}) + 8'({r_d35, 1'b0}) + dv + 8'd5)
                         | ((kind == crfp_pkg::KIND_UP) ? 8'h80 : 8'h40);
            end
            crfp_pkg::OP_EMIT: if (tx_take) r_idx <= r_idx + 3'd1;
            default: ;
        endcase
    end

    // reply frame bytes
    logic [7:0] rb;
    always_comb begin
        if (kind == crfp_pkg::KIND_INFO) begin
            unique case (r_idx)
                3'd0:    rb = r_host;
                3'd1:    rb = 8'hfe;
                3'd2:    rb = 8'h23;
                3'd3:    rb = 8'h02;
                default: rb = 8'h00;
            endcase
        end else begin
            unique case (r_idx)
                3'd0:    rb = r_host;
                3'd1:    rb = 8'hfe;
                3'd2:    rb = 8'h24;
                3'd3:    rb = 8'h04;
                3'd4:    rb = 8'h87;
                3'd6:    rb = r_floor;
                default: rb = 8'h00;
            endcase
        end
    end
    assign tx_last = (kind == crfp_pkg::KIND_INFO) ? (r_idx == 3'd5) : (r_idx == 3'd7);

    assign i_rx.ready           = i_cmd.rx_ready;
    assign o_reply.valid        = i_cmd.tx_valid;
    assign o_reply.reply_byte   = rb;
    assign o_reply.reply_last   = tx_last;
    assign o_reply.command_kind = kind;

    assign o_status.frame_done = frame_done;
    assign o_status.cmp_more   = (r_i < r_len);
    assign o_status.any_match  = |r_match;
    assign o_status.tx_done    = tx_take && tx_last;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_rx.ready && o_reply.valid))
        else $error("receive and reply active together");

    a_frame_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame_done |=> (r_count == '0) && !i_rx.ready)
        else $error("frame end did not clear count or hold input");

    a_bad_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (hdr_chk && hdr_len == 8'h00) |=> (r_count == '0))
        else $error("bad header kept count");

    a_tx_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.tx_done |=> !o_reply.valid)
        else $error("reply continued past last item");

endmodule

### dv/call_request_frame_parser_test.sv
// ----------------------------------------------------------------------------
// call_request_frame_parser_test
// drives directed and random call request text frames into the parser, with sender
// idling and receiver stalls, and checks every reply item against typed items or
// a behavioral predictor of the frame store, header check and template compare
// ----------------------------------------------------------------------------
module call_request_frame_parser_test;

    localparam int STORE_DEPTH = 128;
    localparam int TEXT_SIZE   = STORE_DEPTH + 2;

    typedef struct {
        logic [7:0]      data;
        logic            last;
        crfp_pkg::t_kind kind;
    } t_reply;

    typedef struct {
        string           text;
        int              fill;      // number of 'A' characters appended
        logic [7:0]      tail;      // extra character sent after the text
        bit              has_tail;
        bit              busy;
        int              n_typed;   // typed reply length, 0 = use the predictor
        logic [7:0]      typed[8];
        crfp_pkg::t_kind kind;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    crfp_rx_if    rx_ch();
    crfp_reply_if reply_ch();

    call_request_frame_parser #(
        .BUFFER_DEPTH (STORE_DEPTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_reply (reply_ch)
    );

    always #6 i_clk = ~i_clk;

    // predictor state
    int         char_count;
    logic [7:0] frame_len;
    logic [7:0] frame_mem[STORE_DEPTH];
    logic [7:0] text_buf[TEXT_SIZE];
    t_reply     pending_replies[$];
    int         n_predicted = 0;

    string req_text[3] = '{
        "Type=ELEVATOR&Dong=0101&Ho=1001&Direction=up",
        "Type=ELEVATOR&Dong=0101&Ho=1001&Direction=down",
        "Type=ELEVATOR&Dong=0101&Ho=1001&Direction=info"
    };

    bit failed = 1'b0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_sent = 0;

    function automatic logic [7:0] digit_val(logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        return 8'hFF;
    endfunction

    function automatic logic [7:0] text_char(int pos);
        return pos < TEXT_SIZE ? text_buf[pos] : 8'h00;
    endfunction

    function automatic logic [7:0] req_char(int kind, int pos);
        return pos < req_text[kind].len() ? req_text[kind][pos] : 8'h00;
    endfunction

    function automatic logic [7:0] header_len();
        int v;
        v = 0;
        for (int k = 0; k < 4; k++) if (frame_mem[k] != "0") return 8'd0;
        for (int k = 5; k < 8; k++) begin
            if (digit_val(frame_mem[k]) > 9) return 8'd0;
            v = v * 10 + digit_val(frame_mem[k]);
        end
        return v > 254 ? 8'd0 : v[7:0];
    endfunction

    // three digit field: shift right and insert a leading zero
    function automatic void pad_field(int amp_pos, int start);
        if (text_char(amp_pos) != "&") begin
            for (int k = TEXT_SIZE - 1; k > start; k--) text_buf[k] = text_buf[k-1];
            text_buf[start] = "0";
        end
    endfunction

    function automatic bit request_match(int kind);
        for (int i = 0; i < frame_len; i++) begin
            if (i == 19) i = 23;
            if (i == 27) i = 31;
            if (text_char(i + 8) != req_char(kind, i)) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void parse_char(logic [7:0] c, logic busy);
        int         total, kind, n;
        logic [7:0] fl;
        logic [7:0] reply[8];
        if (busy) return;
        if (c < 8'h10 || c > 8'h7F) begin
            char_count = 0;
            return;
        end
        frame_mem[char_count % STORE_DEPTH] = c;
        if (char_count < STORE_DEPTH - 1) begin
            char_count++;
        end else begin
            char_count = 0;
            frame_mem[0] = c;
        end
        if (char_count < 8) return;
        if (char_count == 8) begin
            frame_len = header_len();
            if (frame_len == 0) char_count = 0;
            return;
        end
        total = frame_len + 8;
        if (char_count < total) return;
        for (int k = 0; k < TEXT_SIZE; k++)
            text_buf[k] = (k < total && k < STORE_DEPTH) ? frame_mem[k] : 8'h00;
        pad_field(31, 27);
        pad_field(39, 35);
        for (kind = 0; kind < 3; kind++) if (request_match(kind)) break;
        char_count = 0;
        if (kind >= 3) return;
        reply[0] = digit_val(text_char(30)) - 8'd1;
        reply[1] = 8'hFE;
        if (kind < 2) begin
            fl = digit_val(text_char(35)) * 8'd10;
            fl = fl + digit_val(text_char(36)) + 8'd5;
            fl = fl | (kind == 0 ? 8'h80 : 8'h40);
            reply[2] = 8'h24; reply[3] = 8'h04; reply[4] = 8'h87;
            reply[5] = 8'h00; reply[6] = fl;    reply[7] = 8'h00;
            n = 8;
        end else begin
            reply[2] = 8'h23; reply[3] = 8'h02; reply[4] = 8'h00; reply[5] = 8'h00;
            n = 6;
        end
        for (int k = 0; k < n; k++) begin
            pending_replies.push_back('{reply[k], k == n - 1, crfp_pkg::t_kind'(kind)});
            n_predicted++;
        end
    endfunction

    // one item through the handshake, predicted as it is driven
    task automatic send_char(logic [7:0] c, logic busy);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            rx_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        rx_ch.valid         <= 1'b1;
        rx_ch.rx_byte       <= c;
        rx_ch.transmit_busy <= busy;
        parse_char(c, busy);
        do @(posedge i_clk); while (!rx_ch.ready);
        if (!busy) items_sent++;
    endtask

    task automatic send_text(string s);
        for (int k = 0; k < s.len(); k++) begin
            send_char(s[k], 1'b0);
            if ($urandom_range(99) < 3) send_char($urandom_range(255), 1'b1);
        end
    endtask

    task automatic wait_drained(int settle);
        int n;
        n = 0;
        rx_ch.valid <= 1'b0;
        while (pending_replies.size() != 0 && n < 20000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (settle) @(posedge i_clk);
    endtask

    function automatic string digits(int n);
        string s;
        s = "";
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 80) s = {s, string'(8'("0" + $urandom_range(9)))};
            else s = {s, string'(8'($urandom_range(8'h10, 8'h7F)))};
        end
        return s;
    endfunction

    task automatic send_random_frame();
        string body, hdr, dir;
        int    len, pos;
        case ($urandom_range(2))
            0: dir = "up";
            1: dir = "down";
            default: dir = "info";
        endcase
        body = {"Type=ELEVATOR&Dong=", digits($urandom_range(3, 4)), "&Ho=",
                digits($urandom_range(3, 4)), "&Direction=", dir};
        if ($urandom_range(99) < 15) begin
            pos = $urandom_range(body.len() - 1);
            body[pos] = $urandom_range(8'h10, 8'h7F);
        end
        len = body.len();
        if ($urandom_range(99) < 8) len = $urandom_range(1, 80);
        hdr = $sformatf("0000%s%03d", string'(8'($urandom_range(8'h10, 8'h7F))), len);
        if ($urandom_range(99) < 5) hdr[$urandom_range(7)] = $urandom_range(8'h10, 8'h7F);
        send_text({hdr, body});
        // trailing noise, sometimes out of range
        if ($urandom_range(99) < 20) begin
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(1)) send_char($urandom_range(8'h00, 8'h0F), 1'b0);
                else send_char($urandom_range(8'h80, 8'hFF), 1'b0);
            end
        end else if ($urandom_range(99) < 10) begin
            repeat ($urandom_range(1, 12)) send_char($urandom_range(255), 1'b0);
        end
    endtask

    // receiver: check accepted reply items, stall at random
    always @(posedge i_clk) begin
        t_reply want;
        if (reply_ch.valid && reply_ch.ready && i_rst_n) begin
            if (pending_replies.size() == 0) begin
                $error("unexpected reply item: reply_byte %h", reply_ch.reply_byte);
                failed = 1'b1;
            end else begin
                want = pending_replies.pop_front();
                if (reply_ch.reply_byte !== want.data) begin
                    $error("reply_byte: expected %h, got %h", want.data, reply_ch.reply_byte);
                    failed = 1'b1;
                end
                if (reply_ch.reply_last !== want.last) begin
                    $error("reply_last: expected %b, got %b", want.last, reply_ch.reply_last);
                    failed = 1'b1;
                end
                if (reply_ch.command_kind !== want.kind) begin
                    $error("command_kind: expected %0d, got %0d", want.kind,
                           reply_ch.command_kind);
                    failed = 1'b1;
                end
            end
        end
        reply_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    initial begin
        #(12 * 3_000_000);
        $display("status: fail");
        $finish;
    end

    initial begin
        t_row rows[$];
        int   mark;
        rx_ch.valid         = 1'b0;
        rx_ch.rx_byte       = 8'h00;
        rx_ch.transmit_busy = 1'b0;
        reply_ch.ready      = 1'b0;
        char_count = 0;
        frame_len  = 8'd0;
        foreach (frame_mem[k]) frame_mem[k] = 8'h00;

        rows = '{
            '{"0000x044Type=ELEVATOR&Dong=0101&Ho=1001&Direction=up", 0, 0, 0, 0,
              8, '{8'h00, 8'hFE, 8'h24, 8'h04, 8'h87, 8'h00, 8'h8F, 8'h00},
              crfp_pkg::KIND_UP},
            '{"0000x046Type=ELEVATOR&Dong=0101&Ho=1001&Direction=down", 0, 0, 0, 0,
              8, '{8'h00, 8'hFE, 8'h24, 8'h04, 8'h87, 8'h00, 8'h4F, 8'h00},
              crfp_pkg::KIND_DOWN},
            '{"0000x046Type=ELEVATOR&Dong=0101&Ho=1001&Direction=info", 0, 0, 0, 0,
              6, '{8'h00, 8'hFE, 8'h23, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00},
              crfp_pkg::KIND_INFO},
            // three digit dong and ho, widened
            '{"0000\x7F042Type=ELEVATOR&Dong=109&Ho=991&Direction=up", 0, 0, 0, 0,
              0, '{default: 8'h00}, crfp_pkg::KIND_UP},
            // non-digit host and floor characters, field extremes
            '{"0000\x10046Type=ELEVATOR&Dong=010\x10&Ho=\x7F\x1001&Direction=down", 0, 0,
              0, 0, 0, '{default: 8'h00}, crfp_pkg::KIND_UP},
            // host digit zero wraps
            '{"0000x044Type=ELEVATOR&Dong=0100&Ho=9901&Direction=up", 0, 0, 0, 0,
              0, '{default: 8'h00}, crfp_pkg::KIND_UP},
            // bad headers
            '{"0001x044Type", 0, 0, 0, 0, 0, '{default: 8'h00}, crfp_pkg::KIND_UP},
            '{"0000x000", 0, 0, 0, 0, 0, '{default: 8'h00}, crfp_pkg::KIND_UP},
            '{"0000x255", 0, 0, 0, 0, 0, '{default: 8'h00}, crfp_pkg::KIND_UP},
            '{"0000x2a4", 0, 0, 0, 0, 0, '{default: 8'h00}, crfp_pkg::KIND_UP},
            // out of range characters clear the count
            '{"0000x044Type=E", 0, 8'h0F, 1, 0, 0, '{default: 8'h00}, crfp_pkg::KIND_UP},
            '{"0000x04", 0, 8'h80, 1, 0, 0, '{default: 8'h00}, crfp_pkg::KIND_UP},
            '{"00", 0, 8'hFF, 1, 0, 0, '{default: 8'h00}, crfp_pkg::KIND_UP},
            '{"0", 0, 8'h00, 1, 0, 0, '{default: 8'h00}, crfp_pkg::KIND_UP},
            // ignored while transmit is busy
            '{"0000x046Type=ELEVATOR&Dong=0101&Ho=1001&Direction=info", 0, 0, 0, 1,
              0, '{default: 8'h00}, crfp_pkg::KIND_UP},
            // mismatch
            '{"0000x044Type=ELEVATOR&Dong=0101&Ho=1001&Direction=ux", 0, 0, 0, 0,
              0, '{default: 8'h00}, crfp_pkg::KIND_UP},
            // short payload, compare skips past the text end
            '{"0000x020Type=ELEVATOR&Dong=0", 0, 0, 0, 0, 0, '{default: 8'h00},
              crfp_pkg::KIND_UP},
            // long frame fills the store and wraps
            '{"0000x254", 119, 0, 0, 0, 0, '{default: 8'h00}, crfp_pkg::KIND_UP},
            '{"0000x044Type=ELEVATOR&Dong=0103&Ho=1201&Direction=up", 0, 0, 0, 0,
              0, '{default: 8'h00}, crfp_pkg::KIND_UP}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            mark = n_predicted;
            for (int k = 0; k < rows[r].text.len(); k++)
                send_char(rows[r].text[k], rows[r].busy);
            repeat (rows[r].fill) send_char("A", rows[r].busy);
            if (rows[r].has_tail) send_char(rows[r].tail, rows[r].busy);
            if (rows[r].n_typed > 0) begin
                // replace only the items predicted for this row
                repeat (n_predicted - mark) void'(pending_replies.pop_back());
                for (int k = 0; k < rows[r].n_typed; k++)
                    pending_replies.push_back('{rows[r].typed[k], k == rows[r].n_typed - 1,
                                                rows[r].kind});
            end
        end
        wait_drained(500);

        items_sent = 0;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            while (items_sent < 105 * (phase + 1)) send_random_frame();
            // hold off until every reply of this phase has arrived
            wait_drained(500);
        end

        recv_stall_pct = 0;
        wait_drained(500);
        if (pending_replies.size() != 0) begin
            $error("reply items still expected: %0d", pending_replies.size());
            failed = 1'b1;
        end
        if (!failed) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
